/* hdl/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// The macros expect signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed: expected follow-up missing");

`endif

/* hdl/sct_pkg.sv */
// Shared types, constants and helper functions of the command tokenizer.
// Used by shell_command_tokenizer_unit; depends on nothing else.
package sct_pkg;

   localparam int MAX_LINE   = 4096;
   localparam int POS_W      = 13;
   localparam int OFS_W      = 12;
   localparam int HEAD_BYTES = 5;
   localparam int HEAD_W     = 8 * HEAD_BYTES;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CNT_W      = 3;

   typedef enum logic [4:0] {
      KIND_WORD     = 5'd0,
      KIND_OR_OR    = 5'd1,
      KIND_AND_AND  = 5'd2,
      KIND_APPEND   = 5'd3,
      KIND_HEREDOC  = 5'd4,
      KIND_PIPE     = 5'd5,
      KIND_AMP      = 5'd6,
      KIND_GT       = 5'd7,
      KIND_LT       = 5'd8,
      KIND_LPAREN   = 5'd9,
      KIND_RPAREN   = 5'd10,
      KIND_SEMI     = 5'd11,
      KIND_NEWLINE  = 5'd12,
      KIND_IF       = 5'd13,
      KIND_FI       = 5'd14,
      KIND_DO       = 5'd15,
      KIND_THEN     = 5'd16,
      KIND_ELSE     = 5'd17,
      KIND_ELIF     = 5'd18,
      KIND_WHILE    = 5'd19,
      KIND_DONE     = 5'd20,
      KIND_FOR      = 5'd21,
      KIND_IN       = 5'd22,
      KIND_END_OK   = 5'd23,
      KIND_UNBAL    = 5'd24,
      KIND_TOO_LONG = 5'd25
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [OFS_W-1:0]  offset;
      logic [POS_W-1:0]  length;
      logic              last;
   } token_type;

   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NUL     = 8'h00;

   // The word head keeps the first byte in the low bits, so each packed
   // reserved word equals the string literal of its letters reversed.
   localparam logic [HEAD_W-1:0] HEAD_IF    = HEAD_W'("fi");
   localparam logic [HEAD_W-1:0] HEAD_FI    = HEAD_W'("if");
   localparam logic [HEAD_W-1:0] HEAD_DO    = HEAD_W'("od");
   localparam logic [HEAD_W-1:0] HEAD_THEN  = HEAD_W'("neht");
   localparam logic [HEAD_W-1:0] HEAD_ELSE  = HEAD_W'("esle");
   localparam logic [HEAD_W-1:0] HEAD_ELIF  = HEAD_W'("file");
   localparam logic [HEAD_W-1:0] HEAD_WHILE = HEAD_W'("elihw");
   localparam logic [HEAD_W-1:0] HEAD_DONE  = HEAD_W'("enod");
   localparam logic [HEAD_W-1:0] HEAD_FOR   = HEAD_W'("rof");
   localparam logic [HEAD_W-1:0] HEAD_IN    = HEAD_W'("ni");

   // Kind of a one-byte operator; KIND_WORD when the byte is no operator.
   function automatic kind_type single_op_kind(input logic [7:0] ch);
      kind_type k;
      unique case (ch)
         CH_PIPE:    k = KIND_PIPE;
         CH_AMP:     k = KIND_AMP;
         CH_GT:      k = KIND_GT;
         CH_LT:      k = KIND_LT;
         CH_LPAREN:  k = KIND_LPAREN;
         CH_RPAREN:  k = KIND_RPAREN;
         CH_SEMI:    k = KIND_SEMI;
         CH_NEWLINE: k = KIND_NEWLINE;
         default:    k = KIND_WORD;
      endcase
      return k;
   endfunction

   // Kind of the doubled operator; KIND_WORD when the byte cannot pair.
   function automatic kind_type double_op_kind(input logic [7:0] ch);
      kind_type k;
      unique case (ch)
         CH_PIPE: k = KIND_OR_OR;
         CH_AMP:  k = KIND_AND_AND;
         CH_GT:   k = KIND_APPEND;
         CH_LT:   k = KIND_HEREDOC;
         default: k = KIND_WORD;
      endcase
      return k;
   endfunction

   function automatic kind_type classify_word(input logic [HEAD_W-1:0] head,
                                              input logic [POS_W-1:0]  len);
      kind_type k;
      k = KIND_WORD;
      if (len == POS_W'(2) && head == HEAD_IF)         k = KIND_IF;
      else if (len == POS_W'(2) && head == HEAD_FI)    k = KIND_FI;
      else if (len == POS_W'(2) && head == HEAD_DO)    k = KIND_DO;
      else if (len == POS_W'(4) && head == HEAD_THEN)  k = KIND_THEN;
      else if (len == POS_W'(4) && head == HEAD_ELSE)  k = KIND_ELSE;
      else if (len == POS_W'(4) && head == HEAD_ELIF)  k = KIND_ELIF;
      else if (len == POS_W'(5) && head == HEAD_WHILE) k = KIND_WHILE;
      else if (len == POS_W'(4) && head == HEAD_DONE)  k = KIND_DONE;
      else if (len == POS_W'(3) && head == HEAD_FOR)   k = KIND_FOR;
      else if (len == POS_W'(2) && head == HEAD_IN)    k = KIND_IN;
      return k;
   endfunction

endpackage

/* hdl/shell_command_tokenizer_unit.sv */
// Command line tokenizer: one byte per request in, tokens out.
// Depends on sct_pkg and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_byte_req
//   rsp      out        rsp_valid/rsp_stall  rsp_token_kind, rsp_start_offset,
//                                            rsp_token_length, rsp_last
//
// A request is registered, decoded combinationally and its tokens (zero to two)
// are written into a four-entry token queue that drives the rsp port.
// One request per cycle is taken while the queue has room for two tokens;
// the queue depth and the rsp side's rate set the sustained rate.
// A first token passes the input register and then the token queue to rsp.
// Reset is synchronous and clears the line state and the queue.
`include "assert_macros.svh"

module shell_command_tokenizer_unit
   import sct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [4:0]          rsp_token_kind,
   output logic [OFS_W-1:0]    rsp_start_offset,
   output logic [POS_W-1:0]    rsp_token_length,
   output logic                rsp_last
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_load;
   logic                step_fire;

   logic                in_single_ff, in_single_in;
   logic                in_double_ff, in_double_in;
   logic                in_word_ff, in_word_in;
   logic [OFS_W-1:0]    word_begin_ff, word_begin_in;
   logic [POS_W-1:0]    word_len_ff, word_len_in;
   logic [HEAD_W-1:0]   word_head_ff, word_head_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [7:0]          held_op_ff, held_op_in;
   logic [OFS_W-1:0]    held_offset_ff, held_offset_in;
   logic                too_long_ff, too_long_in;

   token_type           tok0, tok1;
   logic                push0, push1;

   token_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop;

   // Input register
   assign step_fire = in_valid_ff && (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_stall = in_valid_ff && !step_fire;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Per-byte decode
   always_comb begin
      token_type          op_tok;
      token_type          word_tok;
      token_type          end_tok;
      logic [POS_W-1:0]   pos;
      logic               consumed;
      logic               do_append;
      logic               do_flush;
      logic [OFS_W-1:0]   wb;
      logic [POS_W-1:0]   wl;
      logic [HEAD_W-1:0]  wh;

      in_single_in   = in_single_ff;
      in_double_in   = in_double_ff;
      in_word_in     = in_word_ff;
      word_begin_in  = word_begin_ff;
      word_len_in    = word_len_ff;
      word_head_in   = word_head_ff;
      position_in    = position_ff;
      held_op_in     = held_op_ff;
      held_offset_in = held_offset_ff;
      too_long_in    = too_long_ff;
      tok0           = '0;
      tok1           = '0;
      push0          = 1'b0;
      push1          = 1'b0;
      pos            = position_ff;
      consumed       = 1'b0;
      do_append      = 1'b0;
      do_flush       = 1'b0;
      wb             = word_begin_ff;
      wl             = word_len_ff;
      wh             = word_head_ff;

      op_tok.kind     = single_op_kind(held_op_ff);
      op_tok.offset   = held_offset_ff;
      op_tok.length   = POS_W'(1);
      op_tok.last     = 1'b0;

      word_tok.kind   = (in_single_ff || in_double_ff) ? KIND_WORD
                        : classify_word(word_head_ff, word_len_ff);
      word_tok.offset = word_begin_ff;
      word_tok.length = word_len_ff;
      word_tok.last   = 1'b0;

      if (too_long_ff) begin
         end_tok.kind = KIND_TOO_LONG;
      end else if (in_single_ff || in_double_ff) begin
         end_tok.kind = KIND_UNBAL;
      end else begin
         end_tok.kind = KIND_END_OK;
      end
      end_tok.offset = '0;
      end_tok.length = position_ff;
      end_tok.last   = 1'b1;

      if (step_fire) begin
         if (in_byte_ff == CH_NUL) begin
            // A held operator and an open word never coexist, so the end of
            // line yields at most one pending token plus the end token.
            push0 = 1'b1;
            if (held_op_ff != CH_NUL) begin
               tok0  = op_tok;
               tok1  = end_tok;
               push1 = 1'b1;
            end else if (in_word_ff) begin
               tok0  = word_tok;
               tok1  = end_tok;
               push1 = 1'b1;
            end else begin
               tok0 = end_tok;
            end
            in_single_in   = 1'b0;
            in_double_in   = 1'b0;
            in_word_in     = 1'b0;
            word_begin_in  = '0;
            word_len_in    = '0;
            word_head_in   = '0;
            position_in    = '0;
            held_op_in     = CH_NUL;
            held_offset_in = '0;
            too_long_in    = 1'b0;
         end else if (too_long_ff || position_ff >= POS_W'(MAX_LINE)) begin
            too_long_in = 1'b1;
         end else begin
            position_in = position_ff + POS_W'(1);
            if (held_op_ff != CH_NUL) begin
               held_op_in = CH_NUL;
               push0      = 1'b1;
               tok0       = op_tok;
               if (in_byte_ff == held_op_ff && double_op_kind(held_op_ff) != KIND_WORD) begin
                  tok0.kind   = double_op_kind(held_op_ff);
                  tok0.length = POS_W'(2);
                  consumed    = 1'b1;
               end
            end
            if (!consumed) begin
               if (!in_single_ff && !in_double_ff) begin
                  priority if (in_byte_ff == CH_SQUOTE) begin
                     in_single_in = 1'b1;
                     do_append    = 1'b1;
                  end else if (in_byte_ff == CH_DQUOTE) begin
                     in_double_in = 1'b1;
                     do_append    = 1'b1;
                  end else if (in_byte_ff == CH_SPACE || in_byte_ff == CH_TAB) begin
                     do_flush = 1'b1;
                  end else if (single_op_kind(in_byte_ff) != KIND_WORD) begin
                     do_flush       = 1'b1;
                     held_op_in     = in_byte_ff;
                     held_offset_in = pos[OFS_W-1:0];
                  end else begin
                     do_append = 1'b1;
                  end
               end else begin
                  if (in_single_ff && in_byte_ff == CH_SQUOTE) begin
                     in_single_in = 1'b0;
                  end else if (in_double_ff && in_byte_ff == CH_DQUOTE) begin
                     in_double_in = 1'b0;
                  end
                  do_append = 1'b1;
               end
            end
            // Outside quotes a word that holds quote bytes never matches a
            // reserved head, so classification on raw bytes is enough.
            if (do_flush && in_word_ff) begin
               push0         = 1'b1;
               tok0          = word_tok;
               tok0.kind     = classify_word(word_head_ff, word_len_ff);
               in_word_in    = 1'b0;
               word_begin_in = '0;
               word_len_in   = '0;
               word_head_in  = '0;
            end
            if (do_append) begin
               if (!in_word_ff) begin
                  wb = pos[OFS_W-1:0];
                  wl = '0;
                  wh = '0;
               end
               for (int i = 0; i < HEAD_BYTES; i++) begin
                  if (wl == POS_W'(i)) begin
                     wh[8*i +: 8] = in_byte_ff;
                  end
               end
               in_word_in    = 1'b1;
               word_begin_in = wb;
               word_len_in   = wl + POS_W'(1);
               word_head_in  = wh;
            end
         end
      end
   end

   // Token queue
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(push0) + FIFO_AW'(push1);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
   assign count_in  = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

   assign rsp_valid        = (count_ff != '0);
   assign rsp_token_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_start_offset = fifo_ff[rd_ptr_ff].offset;
   assign rsp_token_length = fifo_ff[rd_ptr_ff].length;
   assign rsp_last         = fifo_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= tok0;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= tok1;
      end
      if (in_load) begin
         in_byte_ff <= req_byte_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         in_single_ff   <= 1'b0;
         in_double_ff   <= 1'b0;
         in_word_ff     <= 1'b0;
         word_begin_ff  <= '0;
         word_len_ff    <= '0;
         word_head_ff   <= '0;
         position_ff    <= '0;
         held_op_ff     <= CH_NUL;
         held_offset_ff <= '0;
         too_long_ff    <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         in_single_ff   <= in_single_in;
         in_double_ff   <= in_double_in;
         in_word_ff     <= in_word_in;
         word_begin_ff  <= word_begin_in;
         word_len_ff    <= word_len_in;
         word_head_ff   <= word_head_in;
         position_ff    <= position_in;
         held_op_ff     <= held_op_in;
         held_offset_ff <= held_offset_in;
         too_long_ff    <= too_long_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   `ASSERT_NEVER(a_queue_overflow, count_ff > CNT_W'(FIFO_DEPTH))
   `ASSERT_NEVER(a_both_quotes, in_single_ff && in_double_ff)
   `ASSERT_NEVER(a_op_and_word, (held_op_ff != CH_NUL) && in_word_ff)
   `ASSERT_NEXT(a_line_restart, step_fire && in_byte_ff == CH_NUL, position_ff == '0 && !too_long_ff)

endmodule
